[sv/iorb_pkg.sv]
// Shared types and constants of the in-order release buffer.
`default_nettype none

package iorb_pkg;

  // Reorder window; slots are addressed by the low bits of the sequence number,
  // so WINDOW must be a power of two.
  localparam int WINDOW       = 16;
  localparam int IDX_BITS     = $clog2(WINDOW);
  localparam int CNT_BITS     = IDX_BITS + 1;
  localparam int SEQ_BITS     = 32;
  localparam int WORD_BITS    = 32;
  localparam int PAYLOAD_BITS = 32;

  localparam int CMDQ_DEPTH    = 2;
  localparam int CMDQ_PTR_BITS = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_BITS = $clog2(CMDQ_DEPTH + 1);

  localparam int OUTQ_DEPTH    = 4;
  localparam int OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_BITS = $clog2(OUTQ_DEPTH + 1);

  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic                    drain;
    logic [SEQ_BITS-1:0]     seq;
    logic [PAYLOAD_BITS-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] payload;
    logic [SEQ_BITS-1:0]  index;
    logic                 status;
    logic                 last;
  } result_t;

endpackage

`default_nettype wire

[sv/in_order_release_buffer_unit.sv]
// Top level: in-order release buffer (reorder buffer with a 16-entry window).
// Flow: each command passes the command queue, the release sequencer and the result stage
// on its way to the result queue; the sequencer takes one command at a time, releases a
// completed run entry by entry, and a drain walks the window slots at one slot per cycle
// (up to 16), holding on a stored slot while the result queue has no room.
// Reset: rst (synchronous) clears the slot valid bits, next expected number and all
// queues at once; slot data needs no clearing, so the block accepts right after reset.
`default_nettype none

module in_order_release_buffer_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input side, queue style
  input  wire logic                           push,
  output logic                                full,
  input  wire logic                           action,
  input  wire logic [iorb_pkg::SEQ_BITS-1:0]  seq_index,
  input  wire logic [iorb_pkg::WORD_BITS-1:0] payload,
  // result side, queue style
  output logic                                empty,
  input  wire logic                           pop,
  output logic [iorb_pkg::WORD_BITS-1:0]      out_payload,
  output logic [iorb_pkg::SEQ_BITS-1:0]       out_index,
  output logic                                status,
  output logic                                last
);

  // Front to back: decoded commands.
  logic                                  cmd_valid;
  iorb_pkg::cmd_t                        cmd;
  logic                                  cmd_pop;

  // Back to result queue.
  logic                                  res_valid;
  iorb_pkg::result_t                     res;
  logic [iorb_pkg::OUTQ_CNT_BITS-1:0]    outq_free;
  iorb_pkg::result_t                     head;

  // Accept each transaction into a short command queue and decode the action there,
  // so the input side keeps taking items while the back end is busy releasing.
  iorb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .action    (action),
    .seq_index (seq_index),
    .payload   (payload),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Carry out one command at a time: window check, duplicate check, slot store
  // addressed by the low sequence bits, then release the run at the expected number
  // (or walk the whole window for a drain). Issue only with room in the result queue.
  iorb_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .outq_free (outq_free),
    .res_valid (res_valid),
    .res       (res)
  );

  // Hold finished results until the consumer takes them.
  iorb_out_queue u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res),
    .free    (outq_free),
    .empty   (empty),
    .pop     (pop),
    .rd_data (head)
  );

  assign out_payload = head.payload;
  assign out_index   = head.index;
  assign status      = head.status;
  assign last        = head.last;

endmodule

`default_nettype wire

[sv/iorb_front.sv]
// Front end: accept transactions, decode the action and queue them as commands.
`default_nettype none

module iorb_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic                           action,
  input  wire logic [iorb_pkg::SEQ_BITS-1:0]  seq_index,
  input  wire logic [iorb_pkg::WORD_BITS-1:0] payload,
  output logic                                cmd_valid,
  output iorb_pkg::cmd_t                      cmd,
  input  wire logic                           cmd_pop
);

  iorb_pkg::cmd_t                          q [iorb_pkg::CMDQ_DEPTH];
  logic [iorb_pkg::CMDQ_PTR_BITS-1:0]      wptr;
  logic [iorb_pkg::CMDQ_PTR_BITS-1:0]      rptr;
  logic [iorb_pkg::CMDQ_CNT_BITS-1:0]      count;
  logic                                    wr_en;
  logic                                    rd_en;
  iorb_pkg::cmd_t                          decoded;

  assign full      = (count == iorb_pkg::CMDQ_CNT_BITS'(iorb_pkg::CMDQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rptr];
  assign wr_en     = push && !full;
  assign rd_en     = cmd_pop && cmd_valid;

  always_comb begin
    decoded.drain = (action == iorb_pkg::ACT_DRAIN);
    decoded.seq   = seq_index;
    decoded.data  = iorb_pkg::PAYLOAD_BITS'(payload);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (wptr == iorb_pkg::CMDQ_PTR_BITS'(iorb_pkg::CMDQ_DEPTH - 1)) ? '0 :
                wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= (rptr == iorb_pkg::CMDQ_PTR_BITS'(iorb_pkg::CMDQ_DEPTH - 1)) ? '0 :
                rptr + 1'b1;
      end
      count <= count + iorb_pkg::CMDQ_CNT_BITS'(wr_en) - iorb_pkg::CMDQ_CNT_BITS'(rd_en);
    end
  end

endmodule

`default_nettype wire

[sv/iorb_engine.sv]
// Back end: slot store, window check, in-order release and drain sequencer.
`default_nettype none

module iorb_engine (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cmd_valid,
  input  wire iorb_pkg::cmd_t                     cmd,
  output logic                                    cmd_pop,
  input  wire logic [iorb_pkg::OUTQ_CNT_BITS-1:0] outq_free,
  output logic                                    res_valid,
  output iorb_pkg::result_t                       res
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]                             state;
  logic [1:0]                             state_next;
  logic [iorb_pkg::WINDOW-1:0]            valid;
  logic [iorb_pkg::CNT_BITS-1:0]          occ;
  logic [iorb_pkg::SEQ_BITS-1:0]          expected;
  logic [iorb_pkg::SEQ_BITS-1:0]          base;
  logic [iorb_pkg::IDX_BITS-1:0]          walk;
  logic [iorb_pkg::CNT_BITS-1:0]          remain;

  logic [iorb_pkg::PAYLOAD_BITS-1:0]      mem [iorb_pkg::WINDOW];
  logic [iorb_pkg::PAYLOAD_BITS-1:0]      rdata;

  logic                                   stage_valid;
  logic [iorb_pkg::SEQ_BITS-1:0]          stage_index;
  logic                                   stage_status;
  logic                                   stage_last;

  logic                                   room;
  logic                                   issue;
  logic [iorb_pkg::SEQ_BITS-1:0]          iss_index;
  logic                                   iss_status;
  logic                                   iss_last;
  logic [iorb_pkg::IDX_BITS-1:0]          raddr;
  logic                                   store;
  logic                                   release_en;
  logic [iorb_pkg::IDX_BITS-1:0]          clr_idx;
  logic                                   drain_start;

  logic [iorb_pkg::SEQ_BITS-1:0]          offset;
  logic [iorb_pkg::IDX_BITS-1:0]          seq_idx;
  logic [iorb_pkg::IDX_BITS-1:0]          exp_idx;
  logic [iorb_pkg::IDX_BITS-1:0]          exp_idx_nxt;
  logic [iorb_pkg::IDX_BITS-1:0]          drn_idx;
  logic                                   reject;

  assign offset      = cmd.seq - expected;
  assign seq_idx     = cmd.seq[iorb_pkg::IDX_BITS-1:0];
  assign exp_idx     = expected[iorb_pkg::IDX_BITS-1:0];
  assign exp_idx_nxt = exp_idx + iorb_pkg::IDX_BITS'(1);
  assign drn_idx     = base[iorb_pkg::IDX_BITS-1:0] + walk;
  assign reject      = (offset[iorb_pkg::SEQ_BITS-1:iorb_pkg::IDX_BITS] != '0) ||
                       valid[seq_idx];
  // Credit: a result already in the stage takes one free slot of the output queue.
  assign room        = (outq_free > iorb_pkg::OUTQ_CNT_BITS'(stage_valid));

  always_comb begin
    state_next  = state;
    cmd_pop     = 1'b0;
    issue       = 1'b0;
    iss_index   = expected;
    iss_status  = iorb_pkg::STATUS_OK;
    iss_last    = 1'b0;
    raddr       = exp_idx;
    store       = 1'b0;
    release_en  = 1'b0;
    clr_idx     = exp_idx;
    drain_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.drain) begin
            cmd_pop = 1'b1;
            if (occ != '0) begin
              drain_start = 1'b1;
              state_next  = ST_DRAIN;
            end
          end else if (reject) begin
            if (room) begin
              cmd_pop    = 1'b1;
              issue      = 1'b1;
              iss_index  = cmd.seq;
              iss_status = iorb_pkg::STATUS_REJECT;
              iss_last   = 1'b1;
            end
          end else begin
            cmd_pop    = 1'b1;
            store      = 1'b1;
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (!valid[exp_idx]) begin
          state_next = ST_IDLE;
        end else if (room) begin
          issue      = 1'b1;
          release_en = 1'b1;
          iss_last   = !valid[exp_idx_nxt];
          if (iss_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_DRAIN: begin
        raddr     = drn_idx;
        clr_idx   = drn_idx;
        iss_index = base + iorb_pkg::SEQ_BITS'(walk);
        if (valid[drn_idx]) begin
          if (room) begin
            issue      = 1'b1;
            release_en = 1'b1;
            iss_last   = (remain == iorb_pkg::CNT_BITS'(1));
            if (iss_last) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Slot memory: write on store, registered read whenever a result issues.
  always_ff @(posedge clk) begin
    if (store) begin
      mem[seq_idx] <= cmd.data;
    end
    if (issue) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      stage_index  <= iss_index;
      stage_status <= iss_status;
      stage_last   <= iss_last;
    end
    if (drain_start) begin
      base <= expected;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      valid       <= '0;
      occ         <= '0;
      expected    <= '0;
      walk        <= '0;
      remain      <= '0;
      stage_valid <= 1'b0;
    end else begin
      state       <= state_next;
      stage_valid <= issue;
      if (store) begin
        valid[seq_idx] <= 1'b1;
        occ            <= occ + iorb_pkg::CNT_BITS'(1);
      end
      if (release_en) begin
        valid[clr_idx] <= 1'b0;
        occ            <= occ - iorb_pkg::CNT_BITS'(1);
        expected       <= expected + iorb_pkg::SEQ_BITS'(1);
      end
      if (drain_start) begin
        walk   <= '0;
        remain <= occ;
      end else if (state == ST_DRAIN) begin
        if (!valid[drn_idx]) begin
          walk <= walk + iorb_pkg::IDX_BITS'(1);
        end else if (release_en) begin
          walk   <= walk + iorb_pkg::IDX_BITS'(1);
          remain <= remain - iorb_pkg::CNT_BITS'(1);
        end
      end
    end
  end

  assign res_valid   = stage_valid;
  assign res.payload = (stage_status == iorb_pkg::STATUS_REJECT) ? '0 :
                       iorb_pkg::WORD_BITS'(rdata);
  assign res.index   = stage_index;
  assign res.status  = stage_status;
  assign res.last    = stage_last;

endmodule

`default_nettype wire

[sv/iorb_out_queue.sv]
// Result queue between the release sequencer and the result ports.
`default_nettype none

module iorb_out_queue (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               wr_en,
  input  wire iorb_pkg::result_t                  wr_data,
  output logic [iorb_pkg::OUTQ_CNT_BITS-1:0]      free,
  output logic                                    empty,
  input  wire logic                               pop,
  output iorb_pkg::result_t                       rd_data
);

  iorb_pkg::result_t                     q [iorb_pkg::OUTQ_DEPTH];
  logic [iorb_pkg::OUTQ_PTR_BITS-1:0]    wptr;
  logic [iorb_pkg::OUTQ_PTR_BITS-1:0]    rptr;
  logic [iorb_pkg::OUTQ_CNT_BITS-1:0]    count;
  logic                                  rd_en;

  assign empty   = (count == '0);
  assign free    = iorb_pkg::OUTQ_CNT_BITS'(iorb_pkg::OUTQ_DEPTH) - count;
  assign rd_data = q[rptr];
  assign rd_en   = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= wptr + iorb_pkg::OUTQ_PTR_BITS'(1);
      end
      if (rd_en) begin
        rptr <= rptr + iorb_pkg::OUTQ_PTR_BITS'(1);
      end
      count <= count + iorb_pkg::OUTQ_CNT_BITS'(wr_en) - iorb_pkg::OUTQ_CNT_BITS'(rd_en);
    end
  end

endmodule

`default_nettype wire

[test/in_order_release_buffer_unit_test.sv]
// Self-checking testbench for the in-order release buffer: directed and random transactions.
`default_nettype none

module in_order_release_buffer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import iorb_pkg::*;

  // Total push/drain transactions offered, directed part included.
  localparam int TOTAL_ITEMS = 270;
  // Cycles to hold after the last expected result: the pipeline latency plus a full
  // drain walk, with margin.
  localparam int SETTLE_CYCLES = 64;
  // Slowest legal run: every transaction releasing a full window, each release waiting
  // out a long pop stall, each push preceded by a long gap. About 2 ms; allow 5x that.
  localparam longint TIMEOUT_NS = 64'd10_000_000;

  // Scoreboard: predicts the release order and checks each popped transaction against
  // the oldest prediction.
  class release_scoreboard;
    logic [WORD_BITS-1:0] slot_word[WINDOW];
    logic [SEQ_BITS-1:0]  slot_seq[WINDOW];
    bit                   slot_busy[WINDOW];
    logic [SEQ_BITS-1:0]  expected_seq;
    result_t              releases[$];
    int                   failures;

    function new();
      for (int s = 0; s < WINDOW; s++) begin
        slot_word[s] = '0;
        slot_seq[s]  = '0;
        slot_busy[s] = 1'b0;
      end
      expected_seq = '0;
      failures     = 0;
    endfunction

    // Associative lookup by sequence number; -1 when not buffered.
    function int find_seq(logic [SEQ_BITS-1:0] tag);
      for (int s = 0; s < WINDOW; s++)
        if (slot_busy[s] && slot_seq[s] == tag) return s;
      return -1;
    endfunction

    // Queue the release of one slot and free it.
    function void release_slot(int s);
      result_t r;
      r.payload = slot_word[s];
      r.index   = slot_seq[s];
      r.status  = STATUS_OK;
      r.last    = 1'b0;
      releases.push_back(r);
      slot_busy[s] = 1'b0;
    endfunction

    // Note an accepted command and queue every result it causes.
    function void note_command(cmd_t c);
      logic [SEQ_BITS-1:0] offset;
      logic [SEQ_BITS-1:0] base;
      result_t             r;
      int                  count;
      int                  s;
      int                  spare;

      count = 0;
      if (c.drain == ACT_DRAIN) begin
        // Release in sequence order relative to the expected number; advance by count.
        base = expected_seq;
        for (int k = 0; k < WINDOW; k++) begin
          s = find_seq(base + SEQ_BITS'(k));
          if (s >= 0) begin
            release_slot(s);
            count++;
          end
        end
        for (int k = 0; k < WINDOW; k++) slot_busy[k] = 1'b0;
        expected_seq = base + SEQ_BITS'(count);
      end else begin
        offset = c.seq - expected_seq;
        spare  = -1;
        for (int k = WINDOW - 1; k >= 0; k--)
          if (!slot_busy[k]) spare = k;
        if (offset >= SEQ_BITS'(WINDOW) || find_seq(c.seq) >= 0 || spare < 0) begin
          // Outside the window or already buffered: one rejection, nothing stored.
          r.payload = '0;
          r.index   = c.seq;
          r.status  = STATUS_REJECT;
          r.last    = 1'b1;
          releases.push_back(r);
          return;
        end
        slot_word[spare] = WORD_BITS'(c.data);
        slot_seq[spare]  = c.seq;
        slot_busy[spare] = 1'b1;
        // Release the longest consecutive run starting at the expected number.
        while (count < WINDOW) begin
          s = find_seq(expected_seq);
          if (s < 0) break;
          release_slot(s);
          expected_seq++;
          count++;
        end
      end
      if (count > 0) begin
        r = releases.pop_back();
        r.last = 1'b1;
        releases.push_back(r);
      end
    endfunction

    function void check_result(logic [WORD_BITS-1:0] got_payload,
                               logic [SEQ_BITS-1:0] got_index,
                               logic got_status, logic got_last);
      result_t want;
      if (releases.size() == 0) begin
        $error("result with nothing pending: out_index %0h out_payload %0h status %0b",
               got_index, got_payload, got_status);
        failures++;
        return;
      end
      want = releases.pop_front();
      if (got_payload !== want.payload) begin
        $error("out_payload: expected %0h, got %0h", want.payload, got_payload);
        failures++;
      end
      if (got_index !== want.index) begin
        $error("out_index: expected %0h, got %0h", want.index, got_index);
        failures++;
      end
      if (got_status !== want.status) begin
        $error("status: expected %0b, got %0b", want.status, got_status);
        failures++;
      end
      if (got_last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got_last);
        failures++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic                 action;
  logic [SEQ_BITS-1:0]  seq_index;
  logic [WORD_BITS-1:0] payload;
  logic                 empty;
  logic                 pop;
  logic [WORD_BITS-1:0] out_payload;
  logic [SEQ_BITS-1:0]  out_index;
  logic                 status;
  logic                 last;

  release_scoreboard sb;
  int                items_sent;
  // When set, both sides run back to back with no idling.
  bit                steady;

  in_order_release_buffer_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .action      (action),
    .seq_index   (seq_index),
    .payload     (payload),
    .empty       (empty),
    .pop         (pop),
    .out_payload (out_payload),
    .out_index   (out_index),
    .status      (status),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if the results never come.
  initial begin
    #(TIMEOUT_NS);
    $display("in_order_release_buffer_unit: mismatch");
    $finish;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one transaction from the falling edge; hold it until the rising edge that
  // accepts it, then note it in the scoreboard.
  task automatic send(input logic drain, input logic [SEQ_BITS-1:0] seq,
                      input logic [PAYLOAD_BITS-1:0] data);
    cmd_t c;
    int   gap;
    c.drain = drain;
    c.seq   = seq;
    c.data  = data;
    gap     = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push      <= 1'b1;
    action    <= drain;
    seq_index <= seq;
    payload   <= data;
    do @(posedge clk); while (full);
    sb.note_command(c);
    items_sent++;
  endtask

  // Result side: pop in runs, stalling at random between them.
  initial begin
    int hold;
    hold = 0;
    pop  = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold > 0 && !steady) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
        hold = 0;
        if ($urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  // Check every popped transaction; outputs sampled before this edge's updates land.
  always @(posedge clk) begin
    if (!rst && pop && !empty)
      sb.check_result(out_payload, out_index, status, last);
  end

  initial begin
    int                  order[WINDOW];
    int                  n;
    int                  j;
    int                  t;
    int                  kind;
    int                  dup;
    logic [SEQ_BITS-1:0] base;
    bit                  first_burst;

    sb          = new();
    items_sent  = 0;
    steady      = 1'b0;
    first_burst = 1'b1;
    rst         = 1'b1;
    push        = 1'b0;
    action      = ACT_PUSH;
    seq_index   = '0;
    payload     = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed: in-order release, gaps then a run, rejections, drains.
    send(ACT_PUSH, 32'd0, 32'hFFFF_FFFF);    // head of window releases at once
    send(ACT_PUSH, 32'd3, 32'h0000_0000);    // gap, nothing released
    send(ACT_PUSH, 32'd2, 32'hA5A5_A5A5);    // gap
    send(ACT_PUSH, 32'd1, 32'h5A5A_5A5A);    // completes run 1..3
    send(ACT_PUSH, 32'd20, 32'h1234_5678);   // one past the window end
    send(ACT_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // wraps far behind: reject
    send(ACT_PUSH, 32'd3, 32'h0BAD_F00D);    // already released: reject
    send(ACT_PUSH, 32'd19, 32'h8000_0001);   // last slot of window, held
    send(ACT_PUSH, 32'd19, 32'h7FFF_FFFE);   // duplicate: reject, keep stored
    send(ACT_PUSH, 32'd6, 32'hDEAD_BEEF);    // another gap
    send(ACT_DRAIN, 32'd0, 32'd0);           // drain with gaps: advance by count
    send(ACT_DRAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // empty drain: nothing released
    send(ACT_PUSH, 32'd6, 32'h0000_0001);    // head again after drain

    // Random: mostly shuffled runs inside the window, the rest noise.
    while (items_sent < TOTAL_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (first_burst || kind < 55) begin
        // Push a shuffled run of consecutive numbers; the last one in closes it.
        if ($urandom_range(0, 5) == 0) steady = ~steady;
        n = first_burst ? WINDOW : $urandom_range(1, WINDOW);
        first_burst = 1'b0;
        for (int i = 0; i < n; i++) order[i] = i;
        for (int i = n - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = order[i];
          order[i] = order[j];
          order[j] = t;
        end
        base = sb.expected_seq;
        for (int i = 0; i < n; i++)
          send(ACT_PUSH, base + SEQ_BITS'(order[i]), $urandom());
      end else if (kind < 70) begin
        send(ACT_PUSH, sb.expected_seq + SEQ_BITS'($urandom_range(0, WINDOW - 1)),
             $urandom());
      end else if (kind < 80) begin
        // Repeat a buffered number if there is one.
        dup = -1;
        for (int s = 0; s < WINDOW; s++)
          if (sb.slot_busy[s] && $urandom_range(0, 1) == 1) dup = s;
        if (dup >= 0) send(ACT_PUSH, sb.slot_seq[dup], $urandom());
        else send(ACT_PUSH, sb.expected_seq, $urandom());
      end else if (kind < 90) begin
        // Outside the window: anywhere past its end, or any number at all.
        if ($urandom_range(0, 1) == 0)
          send(ACT_PUSH, sb.expected_seq + $urandom_range(WINDOW, 32'hFFFF_FFFF),
               $urandom());
        else
          send(ACT_PUSH, $urandom(), $urandom());
      end else begin
        send(ACT_DRAIN, $urandom(), $urandom());
      end
    end

    @(negedge clk);
    push <= 1'b0;

    // Wait for the last predicted release, then hold to catch any stray results.
    while (sb.releases.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.failures == 0 && sb.releases.size() == 0) begin
      $display("in_order_release_buffer_unit: match");
    end else begin
      $display("in_order_release_buffer_unit: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
